>>> hw/rtl/bmsa_pkg.sv
`timescale 1ns / 1ps

package bmsa_pkg;

   localparam int WORD_W    = 64;
   localparam int HALF_W    = WORD_W / 2;
   localparam int SHIFT_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = QPTR_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PARTY        = 2'd0,
      CSR_SHIFT_AMT    = 2'd1,
      CSR_SHIFT_ENABLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] e_opened;
      logic [WORD_W-1:0] f_opened;
      logic [WORD_W-1:0] a_share;
      logic [WORD_W-1:0] b_share;
      logic [WORD_W-1:0] c_share;
      logic              first_term;
      logic              last_term;
   } term_type;

   typedef struct packed {
      logic               party;
      logic [SHIFT_W-1:0] shift_amt;
      logic               shift_enable;
   } cfg_type;

endpackage

>>> hw/rtl/bmsa_front.sv
`timescale 1ns / 1ps

module bmsa_front
   import bmsa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  term_type req_term,
   output logic     pop_valid,
   input  logic     pop_ready,
   output term_type pop_term
);

   term_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign req_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_term  = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_term;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count missed a push");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_W'(QDEPTH)) |-> !req_ready)
      else $error("full queue still accepting");
`endif

endmodule

>>> hw/rtl/bmsa_back.sv
`timescale 1ns / 1ps

module bmsa_back
   import bmsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  term_type          pop_term,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_y_share
);

   // partial products per 64x64 mod 2^64 multiply: lo*lo full, cross terms low half
   logic              advance;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic              s1_first_ff, s2_first_ff, s3_first_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic              s1_p0_ff, s2_p0_ff;
   logic [WORD_W-1:0] s1_c_ff, s2_c_ff, s3_c_ff;
   logic [WORD_W-1:0] s1_ll_ff [3];
   logic [HALF_W-1:0] s1_lh_ff [3];
   logic [HALF_W-1:0] s1_hl_ff [3];
   logic [WORD_W-1:0] s2_prod_ff [3];
   logic [WORD_W-1:0] s3_term_ff, s3_term_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_y_ff, out_y_in;
   logic [WORD_W-1:0] op_x [3];
   logic [WORD_W-1:0] op_y [3];

   assign advance     = !(out_valid_ff && !rsp_ready);
   assign pop_ready   = advance;
   assign rsp_valid   = out_valid_ff;
   assign rsp_y_share = out_y_ff;

   always_comb begin
      op_x[0] = pop_term.e_opened;
      op_y[0] = pop_term.b_share;
      op_x[1] = pop_term.a_share;
      op_y[1] = pop_term.f_opened;
      op_x[2] = pop_term.e_opened;
      op_y[2] = pop_term.f_opened;
   end

   always_comb begin
      s3_term_in = s2_prod_ff[0] + s2_prod_ff[1] + (s2_p0_ff ? s2_prod_ff[2] : '0);
      acc_in     = (s3_first_ff ? s3_c_ff : acc_ff) + s3_term_ff;
      out_valid_in = out_valid_ff;
      out_y_in     = out_y_ff;
      if (advance) begin
         out_valid_in = s4_valid_ff && s4_last_ff;
         if (s4_valid_ff && s4_last_ff) begin
            out_y_in = cfg.shift_enable ? WORD_W'($signed(acc_ff) >>> cfg.shift_amt)
                                        : acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            s1_valid_ff <= pop_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            if (s3_valid_ff) begin
               acc_ff <= acc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_y_ff <= out_y_in;
      if (advance) begin
         s1_first_ff <= pop_term.first_term;
         s1_last_ff  <= pop_term.last_term;
         s1_p0_ff    <= !cfg.party;
         s1_c_ff     <= pop_term.c_share;
         for (int i = 0; i < 3; i++) begin
            s1_ll_ff[i] <= WORD_W'(op_x[i][HALF_W-1:0]) * WORD_W'(op_y[i][HALF_W-1:0]);
            s1_lh_ff[i] <= HALF_W'(op_x[i][HALF_W-1:0] * op_y[i][WORD_W-1:HALF_W]);
            s1_hl_ff[i] <= HALF_W'(op_x[i][WORD_W-1:HALF_W] * op_y[i][HALF_W-1:0]);
         end
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s2_p0_ff    <= s1_p0_ff;
         s2_c_ff     <= s1_c_ff;
         for (int i = 0; i < 3; i++) begin
            s2_prod_ff[i] <= s1_ll_ff[i] + {s1_lh_ff[i] + s1_hl_ff[i], {HALF_W{1'b0}}};
         end
         s3_first_ff <= s2_first_ff;
         s3_last_ff  <= s2_last_ff;
         s3_c_ff     <= s2_c_ff;
         s3_term_ff  <= s3_term_in;
         s4_last_ff  <= s3_last_ff;
      end
   end

`ifndef ASSERT_OFF
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s4_valid_ff && s4_last_ff))
      else $error("result word without a last term");
   a_stall_holds_acc: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> $stable(acc_ff) && $stable(s4_valid_ff))
      else $error("pipeline moved during output stall");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_y_share)))
      else $error("result word changed while waiting");
`endif

endmodule

>>> hw/rtl/beaver_matmul_share_accumulate.sv
`timescale 1ns / 1ps
// Beaver-triple matrix product, one party's share accumulator.
// req_*: one k-term word per handshake (opened e, f; a, b, c shares plus first/last
//   marks). first_term loads c_share before the term is added; last_term
//   makes one rsp_* word carrying y_share.
// csr_*: register writes (index 0 party, 1 shift amount, 2 shift_enable,
//   others ignored); csr_ready is always high. Write only while the block is idle.
// Throughput: one term per cycle, set by the 64-bit accumulate loop, while
//   the result side is not stalled; the three 64-bit products are built from
//   32x32 partial products over two registered stages.
// Result path: rsp_valid rises after the last term passes the term queue, the
//   s1, s2 and s3 stages, the accumulator and the output register, when unstalled.
// Reset clears the accumulator, registers, term queue and pipeline.
// When rsp_ready is low with a word pending, the back pipeline freezes and
//   the 4-entry term queue keeps accepting until full, then req_ready drops.
module beaver_matmul_share_accumulate
   import bmsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_W-1:0]    req_e_opened,
   input  logic [WORD_W-1:0]    req_f_opened,
   input  logic [WORD_W-1:0]    req_a_share,
   input  logic [WORD_W-1:0]    req_b_share,
   input  logic [WORD_W-1:0]    req_c_share,
   input  logic                 req_first_term,
   input  logic                 req_last_term,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_W-1:0]    rsp_y_share,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   term_type req_term, pop_term;
   cfg_type  cfg_ff, cfg_in;
   logic     pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      req_term.e_opened   = req_e_opened;
      req_term.f_opened   = req_f_opened;
      req_term.a_share    = req_a_share;
      req_term.b_share    = req_b_share;
      req_term.c_share    = req_c_share;
      req_term.first_term = req_first_term;
      req_term.last_term  = req_last_term;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PARTY:        cfg_in.party        = csr_wdata[0];
            CSR_SHIFT_AMT:    cfg_in.shift_amt    = csr_wdata[SHIFT_W-1:0];
            CSR_SHIFT_ENABLE: cfg_in.shift_enable = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_term  (req_term),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_term  (pop_term)
   );

   bmsa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_term    (pop_term),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_y_share (rsp_y_share)
   );

endmodule
